>>> rtl/dtte_pkg.sv
// ----------------------------------------------------------------------------
// dtte_pkg
// Types, character codes and calendar tables for the datetime text parser.
// ----------------------------------------------------------------------------
package dtte_pkg;

   // sequencer states: text collection, range check, one state per
   // multiply-add step of the shared unit, result hand-off
   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_CHECK,
      ST_YEARS,
      ST_MONTH,
      ST_DAY,
      ST_HOUR,
      ST_MINUTE,
      ST_SECOND,
      ST_DONE
   } dtte_state_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_T     = 8'h54;

   localparam logic [4:0] POS_DATE_DASH1 = 5'd4;
   localparam logic [4:0] POS_DATE_DASH2 = 5'd7;
   localparam logic [4:0] POS_SEPARATOR  = 5'd10;
   localparam logic [4:0] POS_COLON1     = 5'd13;
   localparam logic [4:0] POS_COLON2     = 5'd16;
   localparam logic [4:0] TEXT_LEN       = 5'd19;
   localparam logic [4:0] POS_SAT        = 5'd20;

   localparam logic [13:0] YEAR_MIN = 14'd2000;
   localparam logic [13:0] YEAR_MAX = 14'd2099;
   localparam logic [7:0]  YEARS_1970_TO_2000 = 8'd30;
   localparam logic [5:0]  LEAPS_1970_TO_2000 = 6'd7;

   localparam logic [6:0] MONTH_MAX  = 7'd12;
   localparam logic [6:0] MONTH_FEB  = 7'd2;
   localparam logic [6:0] FEB_LEAP   = 7'd29;
   localparam logic [6:0] HOUR_MAX   = 7'd23;
   localparam logic [6:0] MINSEC_MAX = 7'd59;

   localparam logic [8:0] DAYS_PER_YEAR  = 9'd365;
   localparam logic [8:0] HOURS_PER_DAY  = 9'd24;
   localparam logic [8:0] SIXTY          = 9'd60;
   localparam logic [8:0] ONE            = 9'd1;

   // days in the year before the first of the month, month 1 to 12
   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // days in a month of a common year
   function automatic logic [6:0] month_length(input logic [3:0] month);
      logic [6:0] days;
      case (month)
         4'd2:    days = 7'd28;
         4'd4:    days = 7'd30;
         4'd6:    days = 7'd30;
         4'd9:    days = 7'd30;
         4'd11:   days = 7'd30;
         default: days = 7'd31;
      endcase
      return days;
   endfunction

endpackage

>>> rtl/datetime_text_to_epoch.sv
// ----------------------------------------------------------------------------
// datetime_text_to_epoch
// Parses YYYY-MM-DD HH:MM:SS (space or T separator) one character per
// transfer and returns a valid flag and the UTC seconds since 1970.
//
// A character transfer is accepted whenever it is offered while the text is
// collected. After the character flagged last, the block stalls its input
// through one range check, six multiply-add steps of a single 32x9
// multiplier with adder and one result load, longer while an earlier result
// still waits in the output register. The result is held in that output
// register until it is taken; the next text may start while that result
// waits. A text that fails a check skips the multiply-add steps and stalls
// the input through the range check and the result load. Years 2000 to
// 2099 are accepted; a failing text gives a valid flag of 0 and zero seconds.
// ----------------------------------------------------------------------------
module datetime_text_to_epoch (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [31:0] rsp_epoch_seconds
);
   import dtte_pkg::*;

   dtte_state_type state_ff, state_in;
   logic [4:0]  pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        shape_ok_ff, shape_ok_in;
   logic        ok_ff, ok_in;
   logic [31:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_valid_res_ff, rsp_valid_res_in;
   logic [31:0] rsp_epoch_ff, rsp_epoch_in;

   logic        req_accept;
   logic        out_free;
   logic        is_digit;
   logic [3:0]  digit;
   logic [6:0]  year_off;
   logic [7:0]  years_since_epoch;
   logic [7:0]  leap_sum;
   logic [5:0]  leap_days;
   logic        year_is_leap;
   logic [3:0]  month_idx;
   logic [8:0]  month_offset;
   logic [6:0]  day_limit;
   logic        year_ok, month_ok, day_ok, time_ok;
   logic [31:0] mul_a;
   logic [8:0]  mul_b;
   logic [31:0] add_c;
   logic [40:0] mul_p;
   logic [31:0] mac;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pos_ff       <= '0;
         year_ff      <= '0;
         month_ff     <= '0;
         day_ff       <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         shape_ok_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         hour_ff      <= hour_in;
         minute_ff    <= minute_in;
         second_ff    <= second_in;
         shape_ok_ff  <= shape_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff            <= ok_in;
      acc_ff           <= acc_in;
      rsp_valid_res_ff <= rsp_valid_res_in;
      rsp_epoch_ff     <= rsp_epoch_in;
   end

   // calendar terms, valid once the year is known to be in range
   always_comb begin
      year_off          = 7'(year_ff - YEAR_MIN);
      years_since_epoch = 8'({1'b0, year_off} + YEARS_1970_TO_2000);
      year_is_leap      = (year_off[1:0] == 2'b00);
      // leap days from 1970 up to the start of the year: 7 + (off + 3) / 4
      leap_sum          = 8'({1'b0, year_off} + 8'd3);
      leap_days         = leap_sum[7:2] + LEAPS_1970_TO_2000;
      month_idx         = month_ff[3:0];
      month_offset      = days_before_month(month_idx) +
                          9'((month_ff > MONTH_FEB) && year_is_leap);
      day_limit         = ((month_ff == MONTH_FEB) && year_is_leap) ?
                          FEB_LEAP : month_length(month_idx);
      year_ok           = (year_ff >= YEAR_MIN) && (year_ff <= YEAR_MAX);
      month_ok          = (month_ff != 7'd0) && (month_ff <= MONTH_MAX);
      day_ok            = (day_ff != 7'd0) && (day_ff <= day_limit);
      time_ok           = (hour_ff <= HOUR_MAX) && (minute_ff <= MINSEC_MAX) &&
                          (second_ff <= MINSEC_MAX);
   end

   // shared multiply-add unit: acc = a * b + c
   always_comb begin
      mul_a = acc_ff;
      mul_b = ONE;
      add_c = '0;
      case (state_ff)
         ST_YEARS: begin
            mul_a = {24'd0, years_since_epoch};
            mul_b = DAYS_PER_YEAR;
            add_c = {26'd0, leap_days};
         end
         ST_MONTH: begin
            add_c = {23'd0, month_offset};
         end
         ST_DAY: begin
            add_c = {25'd0, 7'(day_ff - 7'd1)};
         end
         ST_HOUR: begin
            mul_b = HOURS_PER_DAY;
            add_c = {25'd0, hour_ff};
         end
         ST_MINUTE: begin
            mul_b = SIXTY;
            add_c = {25'd0, minute_ff};
         end
         ST_SECOND: begin
            mul_b = SIXTY;
            add_c = {25'd0, second_ff};
         end
         default: begin
            mul_b = ONE;
         end
      endcase
      mul_p = mul_a * mul_b;
      mac   = mul_p[31:0] + add_c;
   end

   always_comb begin
      state_in         = state_ff;
      pos_in           = pos_ff;
      year_in          = year_ff;
      month_in         = month_ff;
      day_in           = day_ff;
      hour_in          = hour_ff;
      minute_in        = minute_ff;
      second_in        = second_ff;
      shape_ok_in      = shape_ok_ff;
      ok_in            = ok_ff;
      acc_in           = acc_ff;
      rsp_valid_res_in = rsp_valid_res_ff;
      rsp_epoch_in     = rsp_epoch_ff;

      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      req_accept = req_valid && (state_ff == ST_COLLECT);
      is_digit   = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
      // ascii digits carry their value in the low nibble
      digit      = req_char_code[3:0];

      case (state_ff)
         ST_COLLECT: begin
            if (req_accept) begin
               if (pos_ff < TEXT_LEN) begin
                  if ((pos_ff == POS_DATE_DASH1) || (pos_ff == POS_DATE_DASH2)) begin
                     if (req_char_code != CHAR_DASH) shape_ok_in = 1'b0;
                  end else if ((pos_ff == POS_COLON1) || (pos_ff == POS_COLON2)) begin
                     if (req_char_code != CHAR_COLON) shape_ok_in = 1'b0;
                  end else if (pos_ff == POS_SEPARATOR) begin
                     if ((req_char_code != CHAR_SPACE) && (req_char_code != CHAR_T))
                        shape_ok_in = 1'b0;
                  end else if (!is_digit) begin
                     shape_ok_in = 1'b0;
                  end else if (pos_ff < POS_DATE_DASH1) begin
                     year_in = (year_ff << 3) + (year_ff << 1) + {10'd0, digit};
                  end else if (pos_ff < POS_DATE_DASH2) begin
                     month_in = (month_ff << 3) + (month_ff << 1) + {3'd0, digit};
                  end else if (pos_ff < POS_SEPARATOR) begin
                     day_in = (day_ff << 3) + (day_ff << 1) + {3'd0, digit};
                  end else if (pos_ff < POS_COLON1) begin
                     hour_in = (hour_ff << 3) + (hour_ff << 1) + {3'd0, digit};
                  end else if (pos_ff < POS_COLON2) begin
                     minute_in = (minute_ff << 3) + (minute_ff << 1) + {3'd0, digit};
                  end else begin
                     second_in = (second_ff << 3) + (second_ff << 1) + {3'd0, digit};
                  end
               end else begin
                  shape_ok_in = 1'b0;
               end
               if (pos_ff < POS_SAT) pos_in = pos_ff + 5'd1;
               if (req_is_last) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ok_in  = shape_ok_ff && (pos_ff == TEXT_LEN) && year_ok && month_ok &&
                     day_ok && time_ok;
            acc_in = '0;
            state_in = ok_in ? ST_YEARS : ST_DONE;
         end
         ST_YEARS: begin
            acc_in   = mac;
            state_in = ST_MONTH;
         end
         ST_MONTH: begin
            acc_in   = mac;
            state_in = ST_DAY;
         end
         ST_DAY: begin
            acc_in   = mac;
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            acc_in   = mac;
            state_in = ST_MINUTE;
         end
         ST_MINUTE: begin
            acc_in   = mac;
            state_in = ST_SECOND;
         end
         ST_SECOND: begin
            acc_in   = mac;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_valid_res_in = ok_ff;
               rsp_epoch_in     = acc_ff;
               // back to the reset values for the next text
               pos_in      = '0;
               year_in     = '0;
               month_in    = '0;
               day_in      = '0;
               hour_in     = '0;
               minute_in   = '0;
               second_in   = '0;
               shape_ok_in = 1'b1;
               state_in    = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign req_stall         = (state_ff != ST_COLLECT);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = rsp_valid_res_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for datetime_text_to_epoch. Datetime texts are sent one character
// per transfer, and each accepted character also updates a local parser
// model. On the last character, that model queues the expected valid flag and
// seconds since 1970. Results are compared field by field in arrival order.
// The directed texts cover calendar edges and broken shapes. Random texts,
// mostly well formed, run under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;
   import dtte_pkg::*;

   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned EPOCH_YEAR    = 1970;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          ITEMS_PER_PHASE = 340;

   typedef struct packed {
      logic        ok;
      logic [31:0] secs;
   } epoch_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_code;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_valid_res;
   logic [31:0] rsp_epoch_seconds;

   // parser model state
   logic [4:0]  txt_pos;
   logic [13:0] year_acc;
   logic [6:0]  month_acc;
   logic [6:0]  day_acc;
   logic [6:0]  hour_acc;
   logic [6:0]  min_acc;
   logic [6:0]  sec_acc;
   logic        form_ok;

   epoch_result_type epoch_expected[$];
   logic [7:0]       text_buf[$];
   int               errors = 0;
   int               chars_sent = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               idle_cycles = 0;

   datetime_text_to_epoch DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_valid_res     (rsp_valid_res),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic bit is_leap(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned leaps_up_to(input int unsigned y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   // odd months up to july and even months from august have 31 days
   function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
      if (m == 2)
         return leap ? 29 : 28;
      return 30 + ((m + m / 8) % 2);
   endfunction

   function automatic epoch_result_type epoch_of_fields(input bit shape_good);
      epoch_result_type r;
      int unsigned      y;
      int unsigned      m;
      int unsigned      d;
      int unsigned      days;
      int unsigned      k;
      bit               leap;
      bit               ok;
      y = year_acc;
      m = month_acc;
      d = day_acc;
      leap = is_leap(y);
      ok = shape_good;
      if (y < 2000 || y > 2099 || m < 1 || m > 12)
         ok = 1'b0;
      if (ok && (d < 1 || d > days_in_month(m, leap)))
         ok = 1'b0;
      if (hour_acc > 23 || min_acc > 59 || sec_acc > 59)
         ok = 1'b0;
      r.ok = ok;
      r.secs = '0;
      if (ok) begin
         days = (y - EPOCH_YEAR) * 365 + leaps_up_to(y - 1) - leaps_up_to(EPOCH_YEAR - 1);
         for (k = 1; k < m; k++)
            days += days_in_month(k, leap);
         days += d - 1;
         r.secs = days * SECS_PER_DAY + hour_acc * SECS_PER_HOUR + min_acc * SECS_PER_MIN
                  + sec_acc;
      end
      return r;
   endfunction

   task automatic clear_text_state();
      txt_pos = '0;
      year_acc = '0;
      month_acc = '0;
      day_acc = '0;
      hour_acc = '0;
      min_acc = '0;
      sec_acc = '0;
      form_ok = 1'b1;
   endtask

   task automatic parse_char(input logic [7:0] c, input logic last);
      logic [3:0] digit;
      logic [4:0] p;
      p = txt_pos;
      digit = 4'(c - CHAR_ZERO);
      if (p < TEXT_LEN) begin
         if (p == POS_DATE_DASH1 || p == POS_DATE_DASH2) begin
            if (c != CHAR_DASH) form_ok = 1'b0;
         end else if (p == POS_COLON1 || p == POS_COLON2) begin
            if (c != CHAR_COLON) form_ok = 1'b0;
         end else if (p == POS_SEPARATOR) begin
            if (c != CHAR_SPACE && c != CHAR_T) form_ok = 1'b0;
         end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
            form_ok = 1'b0;
         end else if (p < POS_DATE_DASH1) begin
            year_acc = year_acc * 14'd10 + 14'(digit);
         end else if (p < POS_DATE_DASH2) begin
            month_acc = month_acc * 7'd10 + 7'(digit);
         end else if (p < POS_SEPARATOR) begin
            day_acc = day_acc * 7'd10 + 7'(digit);
         end else if (p < POS_COLON1) begin
            hour_acc = hour_acc * 7'd10 + 7'(digit);
         end else if (p < POS_COLON2) begin
            min_acc = min_acc * 7'd10 + 7'(digit);
         end else begin
            sec_acc = sec_acc * 7'd10 + 7'(digit);
         end
      end else begin
         form_ok = 1'b0;
      end
      if (p < POS_SAT)
         p = p + 5'd1;
      txt_pos = p;
      if (last) begin
         epoch_expected.push_back(epoch_of_fields(form_ok && p == TEXT_LEN));
         clear_text_state();
      end
   endtask

   // ------------------------------------------------------------- transfers

   // entered and left just after a falling edge
   task automatic send_char(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_char_code <= 8'($urandom);
         req_is_last <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      parse_char(c, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_buf.size(); i++)
         send_char(text_buf[i], i == text_buf.size() - 1);
      text_buf.delete();
   endtask

   task automatic load_string(input string s);
      int i;
      text_buf.delete();
      for (i = 0; i < s.len(); i++)
         text_buf.push_back(s[i]);
   endtask

   task automatic send_string(input string s);
      load_string(s);
      send_text();
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (epoch_expected.size() != 0)
         @(negedge clock);
   endtask

   task automatic put_number(input int unsigned v, input int n);
      int unsigned div;
      int          k;
      div = 1;
      for (k = 1; k < n; k++)
         div *= 10;
      for (k = 0; k < n; k++) begin
         text_buf.push_back(CHAR_ZERO + 8'((v / div) % 10));
         div /= 10;
      end
   endtask

   task automatic build_random_text();
      int unsigned y;
      int unsigned mo;
      int unsigned dy;
      int unsigned hh;
      int unsigned mi;
      int unsigned ss;
      int          kind;
      int          n;
      int          k;
      text_buf.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         n = $urandom_range(24, 1);
         for (k = 0; k < n; k++)
            text_buf.push_back(8'($urandom));
         return;
      end
      y = ($urandom_range(9) == 0) ? $urandom_range(2110, 1990) : $urandom_range(2099, 2000);
      if ($urandom_range(19) == 0)
         y = $urandom_range(9999);
      mo = ($urandom_range(9) == 0) ? $urandom_range(13, 0) : $urandom_range(12, 1);
      if ($urandom_range(9) == 0)
         dy = $urandom_range(32, 0);
      else if ($urandom_range(3) == 0)
         dy = days_in_month(mo, is_leap(y));
      else
         dy = $urandom_range(days_in_month(mo, is_leap(y)), 1);
      hh = ($urandom_range(9) == 0) ? $urandom_range(99, 24) : $urandom_range(23);
      mi = ($urandom_range(9) == 0) ? $urandom_range(99, 60) : $urandom_range(59);
      ss = ($urandom_range(9) == 0) ? $urandom_range(99, 60) : $urandom_range(59);
      put_number(y, 4);
      text_buf.push_back(CHAR_DASH);
      put_number(mo, 2);
      text_buf.push_back(CHAR_DASH);
      put_number(dy, 2);
      text_buf.push_back($urandom_range(1) ? CHAR_T : CHAR_SPACE);
      put_number(hh, 2);
      text_buf.push_back(CHAR_COLON);
      put_number(mi, 2);
      text_buf.push_back(CHAR_COLON);
      put_number(ss, 2);
      if (kind >= 82) begin
         case ($urandom_range(2))
            0: text_buf[$urandom_range(18)] = 8'($urandom);
            1: begin
               n = $urandom_range(18, 1);
               while (text_buf.size() > n)
                  void'(text_buf.pop_back());
            end
            default: begin
               n = $urandom_range(4, 1);
               for (k = 0; k < n; k++)
                  text_buf.push_back(8'($urandom));
            end
         endcase
      end
   endtask

   // ----------------------------------------------------------------- tests

   task automatic test_calendar_edges();
      send_string("2000-01-01 00:00:00");
      send_string("2099-12-31T23:59:59");
      send_string("2000-02-29 12:34:56");
      send_string("2024-02-29T06:07:08");
      send_string("2023-02-29 01:02:03");
      send_string("2023-04-31 00:00:00");
      send_string("2023-12-31 23:59:59");
      send_string("1999-12-31 23:59:59");
      send_string("2100-01-01 00:00:00");
      send_string("2050-00-10 10:10:10");
      send_string("2050-13-10 10:10:10");
      send_string("2050-06-00 10:10:10");
      send_string("2050-07-32 10:10:10");
      send_string("2050-06-10 24:00:00");
      send_string("2050-06-10 10:60:00");
      send_string("2050-06-10 10:10:60");
      hold_until_drained();
   endtask

   task automatic test_malformed_text();
      send_string("2031-07-15X10:20:30");
      send_string("2031/07-15 10:20:30");
      send_string("2031-07-15 10.20:30");
      send_string("20a1-07-15 10:20:30");
      send_string("2031-07");
      send_string("7");
      send_string("2031-07-15 10:20:30Z");
      send_string("2031-07-15T10:20:30.250");
      load_string("2031-07-15 10:20:30");
      text_buf[2] = 8'hFF;
      send_text();
      load_string("2031-07-15 10:20:30");
      text_buf[17] = 8'h00;
      send_text();
      // the text after a failed one must parse from a clean state
      send_string("2031-07-15 10:20:30");
      hold_until_drained();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int stop_at;
      bit paused;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = chars_sent + ITEMS_PER_PHASE;
      paused = 1'b0;
      while (chars_sent < stop_at) begin
         build_random_text();
         send_text();
         if (!paused && chars_sent > stop_at - ITEMS_PER_PHASE / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
      end
      hold_until_drained();
   endtask

   // --------------------------------------------------------------- control

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock) begin
      epoch_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (epoch_expected.size() == 0) begin
            $display("%0t: result with nothing expected: valid_res %0b, epoch_seconds %0d",
                     $time, rsp_valid_res, rsp_epoch_seconds);
            errors++;
         end else begin
            want = epoch_expected.pop_front();
            if (rsp_valid_res !== want.ok) begin
               $display("%0t: valid_res mismatch: expected %0b, actual %0b",
                        $time, want.ok, rsp_valid_res);
               errors++;
            end
            if (rsp_epoch_seconds !== want.secs) begin
               $display("%0t: epoch_seconds mismatch: expected %0d, actual %0d",
                        $time, want.secs, rsp_epoch_seconds);
               errors++;
            end
         end
      end
   end

   // no transfer on either side for too long means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog timeout, %0d results outstanding",
                     $time, epoch_expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = '0;
      req_is_last = 1'b0;
      rsp_stall = 1'b0;
      clear_text_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_calendar_edges();
      test_malformed_text();
      test_random_traffic(8, 82);
      test_random_traffic(82, 8);
      test_random_traffic(0, 0);

      hold_until_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && epoch_expected.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
